// ----- sv/ttu_pkg.sv -----
// Shared widths, register codes and the bit-spreading function of the twiddle upload block.
package ttu_pkg;

   // Field widths fixed by the block's register map and stream formats.
   localparam int LOG_W      = 4;
   localparam int COORD_W    = 9;
   localparam int XY_W       = COORD_W + 1;
   localparam int REGION_W   = 10;
   localparam int ADDR_W     = 18;
   localparam int PIXEL_W    = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Wide enough for a coordinate shifted by the largest log size a register can hold.
   localparam int WIDE_W = XY_W + (1 << LOG_W) - 1;

   // Larger log sizes are taken as this one.
   localparam logic [LOG_W-1:0] MAX_LOG_SIDE = 4'd9;

   // Region sides are clamped to this many pixels.
   localparam logic [REGION_W-1:0] MAX_REGION = 10'd512;

   // Register indexes on the configuration port (byte address is four times the index).
   typedef enum logic [2:0] {
      REG_LOG_TEX_WIDTH  = 3'd0,
      REG_LOG_TEX_HEIGHT = 3'd1,
      REG_ORIGIN_COL     = 3'd2,
      REG_ORIGIN_ROW     = 3'd3,
      REG_REGION_WIDTH   = 3'd4,
      REG_REGION_HEIGHT  = 3'd5
   } csr_reg_type;

   // Places bit i of the coordinate on bit 2*i of the result.
   function automatic logic [2*XY_W-1:0] spread_bits(input logic [XY_W-1:0] v);
      logic [2*XY_W-1:0] r;
      r = '0;
      for (int i = 0; i < XY_W; i++) begin
         r[2*i] = v[i];
      end
      return r;
   endfunction

endpackage

// ----- sv/ttu_req_if.sv -----
// Pixel input channel: valid/ready handshake with one 32-bit pixel per transfer.
interface ttu_req_if;
   import ttu_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// ----- sv/ttu_rsp_if.sv -----
// Result channel: valid/ready handshake carrying the twiddled address and the pixel.
interface ttu_rsp_if;
   import ttu_pkg::*;

   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  word_address;
   logic [PIXEL_W-1:0] pixel_out;
   logic               out_of_range;
   logic               last;

   modport source (output valid, output word_address, output pixel_out,
                   output out_of_range, output last, input ready);
   modport sink   (input valid, input word_address, input pixel_out,
                   input out_of_range, input last, output ready);
endinterface

// ----- sv/texture_twiddle_upload_top.sv -----
// Top level of the twiddled texture upload: scan counters, address shuffle and result register.
//
// Usage: software programs the texture size (log2 width and height), the region origin
// and the region size over the APB-style csr_ port while the block is idle, then streams
// the region's pixels in row order on the req channel. For every pixel the rsp channel
// returns the Morton-order word address inside the texture, the pixel itself, a flag when
// the destination lies outside the texture (address then reads zero) and a flag on the
// region's final pixel, after which the scan counters wrap to the region's first pixel.
// A pixel taken at one clock edge is offered on rsp from the next. Throughput is one
// pixel per cycle while rsp is not stalled; the address is a single pass of adders,
// shifts and bit spreading from the scan counters into the result register.
// When the receiver stalls, the result register holds its transfer and req_chan.ready
// stays high only if the waiting result leaves in the same cycle.
// Reset (synchronous, active high) empties the result register, zeroes the scan counters
// and returns the registers to their defaults (region 1 by 1, all else zero).
module texture_twiddle_upload_top (
   input  logic                             clock,
   input  logic                             reset,
   ttu_req_if.sink                          req_chan,
   ttu_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ttu_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ttu_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ttu_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import ttu_pkg::*;

   // Configuration registers.
   logic [LOG_W-1:0]    log_tex_width_ff, log_tex_width_in;
   logic [LOG_W-1:0]    log_tex_height_ff, log_tex_height_in;
   logic [COORD_W-1:0]  origin_col_ff, origin_col_in;
   logic [COORD_W-1:0]  origin_row_ff, origin_row_in;
   logic [REGION_W-1:0] region_width_ff, region_width_in;
   logic [REGION_W-1:0] region_height_ff, region_height_in;

   // Scan position inside the region.
   logic [COORD_W-1:0]  scan_col_ff, scan_col_in;
   logic [COORD_W-1:0]  scan_row_ff, scan_row_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   word_address_ff, word_address_in;
   logic [PIXEL_W-1:0]  pixel_out_ff, pixel_out_in;
   logic                out_of_range_ff, out_of_range_in;
   logic                last_ff, last_in;

   logic                csr_write;
   csr_reg_type         csr_index;
   logic                req_accept;
   logic                rsp_accept;

   logic [LOG_W-1:0]    log_w;
   logic [LOG_W-1:0]    log_h;
   logic [LOG_W-1:0]    log_min;
   logic [REGION_W-1:0] region_w;
   logic [REGION_W-1:0] region_h;
   logic [REGION_W-1:0] region_w_m1;
   logic [REGION_W-1:0] region_h_m1;
   logic [XY_W-1:0]     coord_x;
   logic [XY_W-1:0]     coord_y;
   logic [XY_W-1:0]     low_mask;
   logic [WIDE_W-1:0]   addr_x;
   logic [WIDE_W-1:0]   addr_y;
   logic                outside;
   logic                row_end;
   logic                region_end;

   // Register port: writes complete in the access phase, no wait states.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      log_tex_width_in  = log_tex_width_ff;
      log_tex_height_in = log_tex_height_ff;
      origin_col_in     = origin_col_ff;
      origin_row_in     = origin_row_ff;
      region_width_in   = region_width_ff;
      region_height_in  = region_height_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_LOG_TEX_WIDTH:  log_tex_width_in  = csr_pwdata[LOG_W-1:0];
            REG_LOG_TEX_HEIGHT: log_tex_height_in = csr_pwdata[LOG_W-1:0];
            REG_ORIGIN_COL:     origin_col_in     = csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_ROW:     origin_row_in     = csr_pwdata[COORD_W-1:0];
            REG_REGION_WIDTH:   region_width_in   = csr_pwdata[REGION_W-1:0];
            REG_REGION_HEIGHT:  region_height_in  = csr_pwdata[REGION_W-1:0];
            default: ;
         endcase
      end
   end

   // Read data, zero-extended; unused addresses read zero.
   always_comb begin
      unique case (csr_index)
         REG_LOG_TEX_WIDTH:  csr_prdata = CSR_DATA_W'(log_tex_width_ff);
         REG_LOG_TEX_HEIGHT: csr_prdata = CSR_DATA_W'(log_tex_height_ff);
         REG_ORIGIN_COL:     csr_prdata = CSR_DATA_W'(origin_col_ff);
         REG_ORIGIN_ROW:     csr_prdata = CSR_DATA_W'(origin_row_ff);
         REG_REGION_WIDTH:   csr_prdata = CSR_DATA_W'(region_width_ff);
         REG_REGION_HEIGHT:  csr_prdata = CSR_DATA_W'(region_height_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // Handshakes: a new pixel enters whenever the result register is free or draining.
   assign rsp_accept     = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Clamped sizes.
   assign log_w    = (log_tex_width_ff > MAX_LOG_SIDE) ? MAX_LOG_SIDE : log_tex_width_ff;
   assign log_h    = (log_tex_height_ff > MAX_LOG_SIDE) ? MAX_LOG_SIDE : log_tex_height_ff;
   assign log_min  = (log_w < log_h) ? log_w : log_h;
   assign region_w = (region_width_ff == '0) ? REGION_W'(1) :
                     (region_width_ff > MAX_REGION) ? MAX_REGION : region_width_ff;
   assign region_h = (region_height_ff == '0) ? REGION_W'(1) :
                     (region_height_ff > MAX_REGION) ? MAX_REGION : region_height_ff;
   assign region_w_m1 = region_w - REGION_W'(1);
   assign region_h_m1 = region_h - REGION_W'(1);

   // Destination coordinate and texture bounds check.
   assign coord_x  = XY_W'(origin_col_ff) + XY_W'(scan_col_ff);
   assign coord_y  = XY_W'(origin_row_ff) + XY_W'(scan_row_ff);
   assign outside  = ((coord_x >> log_w) != '0) || ((coord_y >> log_h) != '0);

   // Interleave the low bits up to the smaller side, stack the high bits above them.
   assign low_mask = ~({XY_W{1'b1}} << log_min);
   assign addr_x   = WIDE_W'(spread_bits(coord_x & low_mask))
                   | (WIDE_W'(coord_x & ~low_mask) << log_min);
   assign addr_y   = (WIDE_W'(spread_bits(coord_y & low_mask)) << 1)
                   | (WIDE_W'(coord_y & ~low_mask) << log_min);

   // End of row and end of region.
   assign row_end    = REGION_W'(scan_col_ff) >= region_w_m1;
   assign region_end = row_end && (REGION_W'(scan_row_ff) >= region_h_m1);

   // Scan counters advance on every accepted pixel.
   always_comb begin
      scan_col_in = scan_col_ff;
      scan_row_in = scan_row_ff;
      if (req_accept) begin
         if (region_end) begin
            scan_col_in = '0;
            scan_row_in = '0;
         end else if (row_end) begin
            scan_col_in = '0;
            scan_row_in = scan_row_ff + COORD_W'(1);
         end else begin
            scan_col_in = scan_col_ff + COORD_W'(1);
         end
      end
   end

   // Result register loads on an accepted pixel, empties on a result transfer.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      word_address_in = word_address_ff;
      pixel_out_in    = pixel_out_ff;
      out_of_range_in = out_of_range_ff;
      last_in         = last_ff;
      if (req_accept) begin
         rsp_valid_in    = 1'b1;
         word_address_in = outside ? '0 : addr_x[ADDR_W-1:0] | addr_y[ADDR_W-1:0];
         pixel_out_in    = req_chan.pixel;
         out_of_range_in = outside;
         last_in         = region_end;
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and configuration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         log_tex_width_ff  <= '0;
         log_tex_height_ff <= '0;
         origin_col_ff     <= '0;
         origin_row_ff     <= '0;
         region_width_ff   <= REGION_W'(1);
         region_height_ff  <= REGION_W'(1);
         scan_col_ff       <= '0;
         scan_row_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         log_tex_width_ff  <= log_tex_width_in;
         log_tex_height_ff <= log_tex_height_in;
         origin_col_ff     <= origin_col_in;
         origin_row_ff     <= origin_row_in;
         region_width_ff   <= region_width_in;
         region_height_ff  <= region_height_in;
         scan_col_ff       <= scan_col_in;
         scan_row_ff       <= scan_row_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      word_address_ff <= word_address_in;
      pixel_out_ff    <= pixel_out_in;
      out_of_range_ff <= out_of_range_in;
      last_ff         <= last_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.word_address = word_address_ff;
   assign rsp_chan.pixel_out    = pixel_out_ff;
   assign rsp_chan.out_of_range = out_of_range_ff;
   assign rsp_chan.last         = last_ff;

`ifndef SYNTHESIS
   // An accepted pixel always shows up in the result register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted pixel did not reach the result register");

   // A pixel that ends the region sends both counters back to the origin.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && region_end) |=> (scan_col_ff == '0 && scan_row_ff == '0))
      else $error("scan counters did not wrap after the last pixel");

   // Inside a row the column counter steps by one per transfer.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !row_end) |=>
         (scan_col_ff == $past(scan_col_ff) + COORD_W'(1) && $stable(scan_row_ff)))
      else $error("column counter did not advance");

   // Pixels outside the texture carry a zero address.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_of_range_ff) |-> (word_address_ff == '0))
      else $error("out-of-range pixel has a nonzero address");
`endif

endmodule
